// ----- rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants of the command frame splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfs_pkg;

  localparam logic [7:0] CMD_A      = 8'h01;
  localparam logic [7:0] CMD_B      = 8'h03;
  localparam logic [7:0] CMD_C      = 8'hFF;
  localparam logic [7:0] CMD_LEN    = 8'h04;

  localparam int CNT_W = 33;
  localparam int LEN_W = 32;

  localparam logic [CNT_W-1:0] FIXED_TOTAL = 33'd3;
  localparam logic [CNT_W-1:0] LEN_EXTRA   = 33'd8;
  localparam logic [CNT_W-1:0] HDR_END     = 33'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIXED  = 2'd1,
    PH_GATHER = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [7:0] frame_command;
    logic       first_of_frame;
    logic       last_of_frame;
  } frame_t;

  // registered input beat handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } stage_t;

endpackage

// ----- rtl/cfs_channels.sv -----
// ----------------------------------------------------------------------------
// cfs channels
// Valid/ready channels for the byte stream and the frame byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface cfs_frame_if
  import cfs_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [7:0] frame_command;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (output valid, output frame_byte, output frame_command,
                  output first_of_frame, output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input frame_command,
                  input first_of_frame, input last_of_frame, output ready);
endinterface

// ----- rtl/cfs_in_reg.sv -----
// ----------------------------------------------------------------------------
// cfs_in_reg
// Input register: captures one byte beat and holds it for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfs_in_reg
  import cfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cfs_byte_if.sink     in_chan,
  input  logic         take,
  output stage_t       stage
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_chan.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      data_r <= in_chan.data_byte;
    end
  end

  assign stage.valid     = valid_r;
  assign stage.data_byte = data_r;

endmodule

// ----- rtl/cfs_parser.sv -----
// ----------------------------------------------------------------------------
// cfs_parser
// Frame state, counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfs_parser
  import cfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  stage_t       stage,
  output logic         take,
  cfs_frame_if.source  out_chan
);

  phase_t             phase_r, phase_nxt;
  logic [7:0]         cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   taken_r, taken_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]   gather_r, gather_nxt;
  logic               out_valid_r;
  frame_t             out_r, res_nxt;
  logic               emit;
  logic               adv;
  logic [7:0]         b;

  assign take = !out_valid_r || out_chan.ready;
  assign adv  = stage.valid && take;
  assign b    = stage.data_byte;

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    taken_nxt  = taken_r + 33'd1;
    total_nxt  = total_r;
    gather_nxt = gather_r;
    emit       = 1'b1;
    res_nxt.frame_byte     = b;
    res_nxt.frame_command  = cmd_r;
    res_nxt.first_of_frame = 1'b0;
    res_nxt.last_of_frame  = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        res_nxt.frame_command  = b;
        res_nxt.first_of_frame = 1'b1;
        taken_nxt  = 33'd1;
        gather_nxt = '0;
        cmd_nxt    = b;
        if (b == CMD_A || b == CMD_B || b == CMD_C) begin
          total_nxt = FIXED_TOTAL;
          phase_nxt = PH_FIXED;
        end else if (b == CMD_LEN) begin
          total_nxt = '0;
          phase_nxt = PH_GATHER;
        end else begin
          // unknown start byte is dropped, state untouched
          emit       = 1'b0;
          cmd_nxt    = cmd_r;
          taken_nxt  = taken_r;
          gather_nxt = gather_r;
        end
      end
      PH_GATHER: begin
        gather_nxt = {gather_r[LEN_W-9:0], b};
        if (taken_nxt >= HDR_END) begin
          total_nxt = {1'b0, gather_nxt} + LEN_EXTRA;
          phase_nxt = PH_BODY;
        end
      end
      PH_FIXED, PH_BODY: begin
        if (taken_nxt >= total_r) begin
          res_nxt.last_of_frame = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cmd_r       <= '0;
      taken_r     <= '0;
      total_r     <= '0;
      gather_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r     <= phase_nxt;
        cmd_r       <= cmd_nxt;
        taken_r     <= taken_nxt;
        total_r     <= total_nxt;
        gather_r    <= gather_nxt;
        out_valid_r <= emit;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.frame_byte     = out_r.frame_byte;
  assign out_chan.frame_command  = out_r.frame_command;
  assign out_chan.first_of_frame = out_r.first_of_frame;
  assign out_chan.last_of_frame  = out_r.last_of_frame;

endmodule

// ----- rtl/command_frame_splitter.sv -----
// an accepted byte beat passes the input register, then the parser result register, to its frame beat
// throughput: one byte per cycle while the frame channel does not stall, set by the frame state update
// dropped start bytes give no beat
// reset: synchronous active-low rst_n, waits for a command byte
// ----------------------------------------------------------------------------
// command_frame_splitter
// Cuts a byte stream into command frames marked with first and last flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_frame_splitter
  import cfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  cfs_byte_if.sink     in_chan,
  cfs_frame_if.source  out_chan
);

  stage_t stage;
  logic   take;

  cfs_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (take),
    .stage   (stage)
  );

  cfs_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/sv/command_frame_splitter_test.sv -----
// ----------------------------------------------------------------------------
// command_frame_splitter_test
// Feeds byte beats into the frame splitter and checks every frame beat against
// a frame tracker that runs alongside the block. Directed frames come first:
// unknown start bytes, every fixed command, back-to-back frames and the
// shortest length frame. Random frames, noise and truncated frames follow, and
// the run closes by opening a frame of the largest length. Both channels idle
// and stall in random bursts until the last stretch of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_frame_splitter_test;
  import cfs_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BEATS = 800;

  class frame_scoreboard;
    phase_t           ph;
    logic [7:0]       cmd;
    logic [CNT_W-1:0] taken;
    logic [CNT_W-1:0] total;
    logic [LEN_W-1:0] gather;
    frame_t           expected_q[$];
    int               errors;
    int               checked;
    int               frames_closed;
    int               len_frames;
    int               dropped;

    function new();
      ph            = PH_IDLE;
      cmd           = '0;
      taken         = '0;
      total         = '0;
      gather        = '0;
      errors        = 0;
      checked       = 0;
      frames_closed = 0;
      len_frames    = 0;
      dropped       = 0;
    endfunction

    // track the frame state for one accepted byte, returns 1 when a beat is due
    function bit note_byte(input logic [7:0] b);
      frame_t f;
      if (ph == PH_IDLE) begin
        if (b == CMD_A || b == CMD_B || b == CMD_C) begin
          ph    = PH_FIXED;
          total = FIXED_TOTAL;
        end else if (b == CMD_LEN) begin
          ph    = PH_GATHER;
          total = '0;
          len_frames++;
        end else begin
          dropped++;
          return 1'b0;
        end
        cmd    = b;
        taken  = 1;
        gather = '0;
        f = '{frame_byte: b, frame_command: cmd, first_of_frame: 1'b1, last_of_frame: 1'b0};
      end else begin
        taken = taken + 1'b1;
        f = '{frame_byte: b, frame_command: cmd, first_of_frame: 1'b0, last_of_frame: 1'b0};
        if (ph == PH_GATHER) begin
          gather = {gather[LEN_W-9:0], b};
          if (taken >= HDR_END) begin
            total = {1'b0, gather} + LEN_EXTRA;
            ph    = PH_BODY;
          end
        end else if (taken >= total) begin
          f.last_of_frame = 1'b1;
          ph = PH_IDLE;
          frames_closed++;
        end
      end
      expected_q.push_back(f);
      return 1'b1;
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 30) $display("mismatch: %s", what);
    endtask

    task check_beat(input frame_t got);
      frame_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("beat with nothing pending, byte %02h", got.frame_byte));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got.frame_byte !== want.frame_byte)
          report($sformatf("beat %0d frame_byte %02h, want %02h",
                           checked, got.frame_byte, want.frame_byte));
        if (got.frame_command !== want.frame_command)
          report($sformatf("beat %0d frame_command %02h, want %02h",
                           checked, got.frame_command, want.frame_command));
        if (got.first_of_frame !== want.first_of_frame)
          report($sformatf("beat %0d first_of_frame %b, want %b",
                           checked, got.first_of_frame, want.first_of_frame));
        if (got.last_of_frame !== want.last_of_frame)
          report($sformatf("beat %0d last_of_frame %b, want %b",
                           checked, got.last_of_frame, want.last_of_frame));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  bit   quiet = 1'b0;
  bit   gaps_on = 1'b1;
  int   random_beats = 0;
  int   bytes_fed = 0;

  frame_scoreboard sb;

  cfs_byte_if  in_if ();
  cfs_frame_if out_if ();

  command_frame_splitter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycles, sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : frame_monitor
    frame_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.frame_byte     = out_if.frame_byte;
      got.frame_command  = out_if.frame_command;
      got.first_of_frame = out_if.first_of_frame;
      got.last_of_frame  = out_if.last_of_frame;
      sb.check_beat(got);
    end
  end

  // sink side: ready runs of random length broken by stall bursts
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_fed++;
    if (sb.note_byte(b)) random_beats++;
  endtask

  // finish whatever frame is open; zero length bytes keep a cut header short
  task automatic close_open_frame();
    while (sb.ph != PH_IDLE)
      send_byte(sb.ph == PH_GATHER ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_length_frame(input logic [31:0] len);
    send_byte(CMD_LEN);
    send_byte(len[31:24]);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    repeat (len + 3) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    int          kind;
    int          pick;
    logic [7:0]  b;
    logic [31:0] len;
    kind    = $urandom_range(0, 9);
    gaps_on = ($urandom_range(0, 3) != 0);
    if (kind < 7) begin
      close_open_frame();
      pick = $urandom_range(0, 3);
      if (pick == 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      len = $urandom_range(0, 12);
        else if (pick < 95) len = $urandom_range(13, 60);
        else                len = $urandom_range(61, 300);
        send_length_frame(len);
      end else begin
        send_byte(pick == 0 ? CMD_A : pick == 1 ? CMD_B : CMD_C);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
    end else if (kind < 9) begin
      // noise, kept away from the length command so no huge frame opens
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CMD_LEN) b = 8'hA5;
        send_byte(b);
      end
    end else begin
      // cut-short fixed frame, filled up by later noise bytes or by close_open_frame
      close_open_frame();
      send_byte($urandom_range(0, 1) ? CMD_A : CMD_C);
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] directed_q[$];
    bit         drained;
    sb = new();
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unknown start bytes, each fixed command, back-to-back frames,
    // the shortest length frame with command values in its body
    directed_q = '{8'h00, 8'h05, 8'hFE, 8'h7F,
                   CMD_A, CMD_LEN, CMD_C,
                   CMD_B, 8'h00, 8'h80,
                   CMD_C, CMD_C, CMD_A,
                   CMD_LEN, 8'h00, 8'h00, 8'h00, 8'h00, CMD_A, CMD_LEN, CMD_C,
                   8'h80, 8'h02};
    foreach (directed_q[i]) send_byte(directed_q[i]);
    send_length_frame(32'd1);

    random_beats = 0;
    drained      = 1'b0;
    while (random_beats < RANDOM_BEATS) begin
      send_random_frame();
      if (!drained && random_beats >= RANDOM_BEATS / 2) begin
        in_if.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_q.size() != 0);
        drained = 1'b1;
      end
      if (random_beats >= RANDOM_BEATS * 5 / 6) quiet = 1'b1;
    end
    close_open_frame();

    // open the longest possible frame; it stays open at the end of the run
    send_byte(CMD_LEN);
    repeat (4) send_byte(8'hFF);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    in_if.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("fed %0d bytes, checked %0d frame beats, closed %0d frames, %0d dropped",
             bytes_fed, sb.checked, sb.frames_closed, sb.dropped);
    $display("%0d length frames opened, the last one of the largest length",
             sb.len_frames);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cfs_pkg.sv
rtl/cfs_channels.sv
rtl/cfs_in_reg.sv
rtl/cfs_parser.sv
rtl/command_frame_splitter.sv
tb/sv/command_frame_splitter_test.sv
